// ===== rtl/pll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_pkg
// Shared types, token codes and the keyword table of the lexer.
// ----------------------------------------------------------------------------
package pll_pkg;

  localparam int SYMBOL_LEN = 64;
  localparam int NUM_KW     = 23;
  localparam int QDEPTH     = 4;

  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_NUM_OVF, M_CHR_OPEN, M_CHR_GOT, M_STR,
    M_COLON, M_LESS, M_GREATER
  } mode_t;

  localparam logic [5:0] K_END     = 6'd0;
  localparam logic [5:0] K_PLUS    = 6'd24;
  localparam logic [5:0] K_MINUS   = 6'd25;
  localparam logic [5:0] K_MULT    = 6'd26;
  localparam logic [5:0] K_DIV     = 6'd27;
  localparam logic [5:0] K_COMMA   = 6'd28;
  localparam logic [5:0] K_PERIOD  = 6'd29;
  localparam logic [5:0] K_SEMI    = 6'd30;
  localparam logic [5:0] K_COLON   = 6'd31;
  localparam logic [5:0] K_LBRACK  = 6'd32;
  localparam logic [5:0] K_RBRACK  = 6'd33;
  localparam logic [5:0] K_LPAREN  = 6'd34;
  localparam logic [5:0] K_RPAREN  = 6'd35;
  localparam logic [5:0] K_ASSIGN  = 6'd36;
  localparam logic [5:0] K_EQ      = 6'd37;
  localparam logic [5:0] K_NEQ     = 6'd38;
  localparam logic [5:0] K_LSS     = 6'd39;
  localparam logic [5:0] K_LEQ     = 6'd40;
  localparam logic [5:0] K_GTR     = 6'd41;
  localparam logic [5:0] K_GEQ     = 6'd42;
  localparam logic [5:0] K_IDENT   = 6'd43;
  localparam logic [5:0] K_INT     = 6'd44;
  localparam logic [5:0] K_CHAR    = 6'd45;
  localparam logic [5:0] K_STRING  = 6'd46;
  localparam logic [5:0] K_UNKNOWN = 6'd47;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_APOS     = 2'd1;
  localparam logic [1:0] E_QUOTE    = 2'd2;
  localparam logic [1:0] E_OVERFLOW = 2'd3;

  typedef struct packed {
    logic        last;
    logic [1:0]  err;
    logic [15:0] line;
    logic [6:0]  len;
    logic [30:0] value;
    logic [5:0]  kind;
  } tok_t;

  // keyword text, last character in the lowest byte
  localparam logic [71:0] KW_STR [NUM_KW] = '{
    72'("array"), 72'("begin"), 72'("case"), 72'("char"), 72'("const"),
    72'("do"), 72'("downto"), 72'("else"), 72'("end"), 72'("for"),
    72'("function"), 72'("if"), 72'("integer"), 72'("of"),
    72'("procedure"), 72'("read"), 72'("repeat"), 72'("then"), 72'("to"),
    72'("until"), 72'("var"), 72'("while"), 72'("write")
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd5, 4'd4, 4'd4, 4'd5, 4'd2, 4'd6, 4'd4, 4'd3, 4'd3, 4'd8, 4'd2,
    4'd7, 4'd2, 4'd9, 4'd4, 4'd6, 4'd4, 4'd2, 4'd5, 4'd3, 4'd5, 4'd5
  };

  // character at position pos of keyword k; pos must be below its length
  function automatic logic [7:0] kw_at(input int k, input logic [3:0] pos);
    logic [3:0] idx;
    idx = KW_LEN[k] - 4'd1 - pos;
    return KW_STR[k][{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_MULT;
      "/":     k = K_DIV;
      ",":     k = K_COMMA;
      ".":     k = K_PERIOD;
      ";":     k = K_SEMI;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "=":     k = K_EQ;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/pll_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_scan
// Front end: scans one character per cycle while acc is high and produces up to two tokens.
// ----------------------------------------------------------------------------
module pll_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         c,
  input  logic               eoi,
  output logic               wr0_en,
  output pll_pkg::tok_t      wr0,
  output logic               wr1_en,
  output pll_pkg::tok_t      wr1
);

  pll_pkg::mode_t mode_r, mode_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [30:0] num_r, num_nxt;
  logic [15:0] line_r, line_nxt;
  logic [7:0]  lit_r, lit_nxt;
  logic [pll_pkg::NUM_KW-1:0] cand_r, cand_nxt;

  logic is_space, is_alpha, is_digit, is_print, nl_inc;
  logic [15:0] line_inc;
  logic [34:0] num10;
  logic        num_ovf;
  logic [3:0]  pos;
  logic [pll_pkg::NUM_KW-1:0] cand_step, cand_first;
  logic [5:0]  word_kind;
  logic        word_hit;
  logic        restart;
  logic        a_v, b_v;
  pll_pkg::tok_t a_t, b_t;

  assign is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = (c >= "0" && c <= "9");
  assign is_print = (c >= 8'd32 && c <= 8'd126 && c != "\"");
  assign nl_inc   = (c == 8'd10) && (line_r != 16'hFFFF);
  assign line_inc = nl_inc ? line_r + 16'd1 : line_r;

  assign num10   = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0} + {31'd0, c[3:0] - 4'd0};
  assign num_ovf = num10 > {4'd0, pll_pkg::INT_MAX31};

  assign pos = (len_r < 7'd9) ? len_r[3:0] : 4'd0;

  // narrow the keyword candidates one character at a time
  always_comb begin
    word_hit  = 1'b0;
    word_kind = pll_pkg::K_IDENT;
    for (int k = 0; k < pll_pkg::NUM_KW; k++) begin
      cand_step[k]  = cand_r[k] && (len_r < {3'd0, pll_pkg::KW_LEN[k]}) &&
                      (pll_pkg::kw_at(k, pos) == c);
      cand_first[k] = (pll_pkg::kw_at(k, 4'd0) == c);
      if (cand_r[k] && len_r == {3'd0, pll_pkg::KW_LEN[k]}) begin
        word_hit  = 1'b1;
        word_kind = 6'(k + 1);
      end
    end
  end

  // the current character starts a new token after the pending one closes
  always_comb begin
    restart = 1'b0;
    unique case (mode_r)
      pll_pkg::M_IDLE:     restart = 1'b1;
      pll_pkg::M_IDENT:    restart = !(is_alpha || is_digit);
      pll_pkg::M_NUM,
      pll_pkg::M_NUM_OVF:  restart = !is_digit;
      pll_pkg::M_COLON:    restart = (c != "=");
      pll_pkg::M_LESS:     restart = (c != ">") && (c != "=");
      pll_pkg::M_GREATER:  restart = (c != "=");
      default:             restart = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    if (eoi) begin
      mode_nxt = pll_pkg::M_IDLE;
    end else if (restart) begin
      if (is_space)          mode_nxt = pll_pkg::M_IDLE;
      else if (is_alpha)     mode_nxt = pll_pkg::M_IDENT;
      else if (is_digit)     mode_nxt = pll_pkg::M_NUM;
      else if (c == "'")     mode_nxt = pll_pkg::M_CHR_OPEN;
      else if (c == "\"")    mode_nxt = pll_pkg::M_STR;
      else if (c == ":")     mode_nxt = pll_pkg::M_COLON;
      else if (c == "<")     mode_nxt = pll_pkg::M_LESS;
      else if (c == ">")     mode_nxt = pll_pkg::M_GREATER;
      else                   mode_nxt = pll_pkg::M_IDLE;
    end else begin
      unique case (mode_r)
        pll_pkg::M_NUM:      mode_nxt = (is_digit && num_ovf) ? pll_pkg::M_NUM_OVF
                                                               : pll_pkg::M_NUM;
        pll_pkg::M_CHR_OPEN: mode_nxt = pll_pkg::M_CHR_GOT;
        pll_pkg::M_CHR_GOT:  mode_nxt = pll_pkg::M_IDLE;
        pll_pkg::M_STR:      mode_nxt = is_print ? pll_pkg::M_STR : pll_pkg::M_IDLE;
        pll_pkg::M_COLON,
        pll_pkg::M_LESS,
        pll_pkg::M_GREATER:  mode_nxt = pll_pkg::M_IDLE;
        default:             mode_nxt = mode_r;
      endcase
    end
  end

  always_comb begin
    len_nxt  = len_r;
    num_nxt  = num_r;
    line_nxt = line_r;
    lit_nxt  = lit_r;
    cand_nxt = cand_r;
    a_v = 1'b0;
    b_v = 1'b0;
    a_t = '{last: 1'b0, err: pll_pkg::E_NONE, line: line_r, len: 7'd0,
            value: 31'd0, kind: pll_pkg::K_END};
    b_t = a_t;

    if (eoi) begin
      a_v = 1'b1;
      unique case (mode_r)
        pll_pkg::M_IDENT: begin
          a_t.kind = word_kind;
          a_t.len  = word_hit ? 7'd0 : len_r;
        end
        pll_pkg::M_NUM:      begin a_t.kind = pll_pkg::K_INT; a_t.value = num_r; end
        pll_pkg::M_NUM_OVF: begin
          a_t.kind = pll_pkg::K_INT; a_t.value = num_r; a_t.err = pll_pkg::E_OVERFLOW;
        end
        pll_pkg::M_CHR_OPEN: begin a_t.kind = pll_pkg::K_CHAR; a_t.err = pll_pkg::E_APOS; end
        pll_pkg::M_CHR_GOT: begin
          a_t.kind = pll_pkg::K_CHAR; a_t.value = {23'd0, lit_r}; a_t.err = pll_pkg::E_APOS;
        end
        pll_pkg::M_STR: begin
          a_t.kind = pll_pkg::K_STRING; a_t.len = len_r; a_t.err = pll_pkg::E_QUOTE;
        end
        pll_pkg::M_COLON:   a_t.kind = pll_pkg::K_COLON;
        pll_pkg::M_LESS:    a_t.kind = pll_pkg::K_LSS;
        pll_pkg::M_GREATER: a_t.kind = pll_pkg::K_GTR;
        default:            a_v = 1'b0;
      endcase
      b_v      = 1'b1;
      len_nxt  = 7'd0;
      num_nxt  = 31'd0;
      line_nxt = 16'd1;
      lit_nxt  = 8'd0;
      cand_nxt = '0;
    end else begin
      // close or extend the pending token
      unique case (mode_r)
        pll_pkg::M_IDENT: begin
          if (!restart) begin
            if (len_r < 7'(pll_pkg::SYMBOL_LEN)) begin
              len_nxt  = len_r + 7'd1;
              cand_nxt = cand_step;
            end
          end else begin
            a_v = 1'b1; a_t.kind = word_kind; a_t.len = word_hit ? 7'd0 : len_r;
          end
        end
        pll_pkg::M_NUM: begin
          if (!restart) num_nxt = num_ovf ? pll_pkg::INT_MAX31 : num10[30:0];
          else begin a_v = 1'b1; a_t.kind = pll_pkg::K_INT; a_t.value = num_r; end
        end
        pll_pkg::M_NUM_OVF: begin
          if (restart) begin
            a_v = 1'b1; a_t.kind = pll_pkg::K_INT; a_t.value = num_r;
            a_t.err = pll_pkg::E_OVERFLOW;
          end
        end
        pll_pkg::M_CHR_OPEN: begin
          line_nxt = line_inc;
          lit_nxt  = c;
        end
        pll_pkg::M_CHR_GOT: begin
          line_nxt = line_inc;
          a_v = 1'b1; a_t.kind = pll_pkg::K_CHAR; a_t.value = {23'd0, lit_r};
          a_t.line = line_inc;
          a_t.err  = (c == "'") ? pll_pkg::E_NONE : pll_pkg::E_APOS;
        end
        pll_pkg::M_STR: begin
          if (is_print) begin
            if (len_r < 7'(pll_pkg::SYMBOL_LEN)) len_nxt = len_r + 7'd1;
          end else begin
            line_nxt = line_inc;
            a_v = 1'b1; a_t.kind = pll_pkg::K_STRING; a_t.len = len_r;
            a_t.line = line_inc;
            a_t.err  = (c == "\"") ? pll_pkg::E_NONE : pll_pkg::E_QUOTE;
          end
        end
        pll_pkg::M_COLON: begin
          a_v = 1'b1; a_t.kind = restart ? pll_pkg::K_COLON : pll_pkg::K_ASSIGN;
        end
        pll_pkg::M_LESS: begin
          a_v = 1'b1;
          if (restart)       a_t.kind = pll_pkg::K_LSS;
          else if (c == ">") a_t.kind = pll_pkg::K_NEQ;
          else               a_t.kind = pll_pkg::K_LEQ;
        end
        pll_pkg::M_GREATER: begin
          a_v = 1'b1; a_t.kind = restart ? pll_pkg::K_GTR : pll_pkg::K_GEQ;
        end
        default: ;
      endcase

      if (restart) begin
        if (is_space) begin
          line_nxt = line_inc;
        end else if (is_alpha) begin
          len_nxt  = 7'd1;
          cand_nxt = cand_first;
        end else if (is_digit) begin
          num_nxt = {27'd0, c[3:0]};
        end else if (c == "'") begin
          lit_nxt = 8'd0;
        end else if (c == "\"") begin
          len_nxt = 7'd0;
        end else if (c != ":" && c != "<" && c != ">") begin
          b_v = 1'b1; b_t.kind = pll_pkg::single_kind(c);
        end
      end
    end
  end

  always_comb begin
    wr0        = a_v ? a_t : b_t;
    wr0.last   = !(a_v && b_v);
    wr0_en     = acc && (a_v || b_v);
    wr1        = b_t;
    wr1.last   = 1'b1;
    wr1_en     = acc && a_v && b_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pll_pkg::M_IDLE;
      len_r  <= 7'd0;
      num_r  <= 31'd0;
      line_r <= 16'd1;
      lit_r  <= 8'd0;
      cand_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      num_r  <= num_nxt;
      line_r <= line_nxt;
      lit_r  <= lit_nxt;
      cand_r <= cand_nxt;
    end
  end

endmodule

// ===== rtl/pll_tokq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_tokq
// Back end: token queue taking two writes a cycle, drained one per request.
// ----------------------------------------------------------------------------
module pll_tokq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr0_en,
  input  pll_pkg::tok_t wr0,
  input  logic          wr1_en,
  input  pll_pkg::tok_t wr1,
  output logic          room,
  output logic          rd_valid,
  input  logic          rd_ready,
  output pll_pkg::tok_t rd_data
);

  localparam int AW = $clog2(pll_pkg::QDEPTH);

  pll_pkg::tok_t mem_r [pll_pkg::QDEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  // keep space for two tokens from the next request
  assign room     = (cnt_r <= (AW + 1)'(pll_pkg::QDEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + AW'(wr0_en) + AW'(wr1_en);
    rp_nxt  = rp_r + AW'(pop);
    cnt_nxt = cnt_r + (AW + 1)'(wr0_en) + (AW + 1)'(wr1_en) - (AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr0_en) mem_r[wp_r] <= wr0;
    if (wr1_en) mem_r[wp_r + AW'(1)] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/pascal_like_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pascal_like_lexer
// Streaming lexer: one character per request in, tokens out.
// ----------------------------------------------------------------------------
// One character is taken every cycle while the four-entry token queue has room
// for two tokens; a character closes at most one pending token and may emit a
// second. The output side drains one token per cycle while out_tready is high,
// so sustained rate is set by the token count: one character per cycle for up
// to one token per character. tlast marks the final token caused by a
// character; end of input (in_tuser) flushes and emits kind 0.
module pascal_like_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code[7:0]
  input  logic [0:0]  in_tuser,   // end_of_input[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // token_kind[5:0], token_value[36:6],
                                  // lexeme_len[43:37], line_number[59:44],
                                  // error_code[61:60], zero[63:62]
  output logic        out_tlast
);

  logic          acc, wr0_en, wr1_en, room;
  pll_pkg::tok_t wr0, wr1, head;

  assign in_tready = room;
  assign acc       = in_tvalid && room;

  pll_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .c      (in_tdata),
    .eoi    (in_tuser[0]),
    .wr0_en (wr0_en),
    .wr0    (wr0),
    .wr1_en (wr1_en),
    .wr1    (wr1)
  );

  pll_tokq u_tokq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr0_en   (wr0_en),
    .wr0      (wr0),
    .wr1_en   (wr1_en),
    .wr1      (wr1),
    .room     (room),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = {2'b00, head.err, head.line, head.len, head.value, head.kind};
  assign out_tlast = head.last;

endmodule
